/* rtl/spf_pkg.sv */
package spf_pkg;

   // Register reset values
   localparam logic [15:0] SYNC_WORD_RESET = 16'hEF01;
   localparam logic [31:0] DEV_ADDR_RESET  = 32'hFFFF_FFFF;

   // Transmit payload count ceiling
   localparam int MAX_PAYLOAD = 64;

   // Header bytes ahead of the first payload byte
   localparam int HDR_BYTES = 9;

   // Largest number of result beats one input beat can cause
   localparam int MAX_RESULTS = 12;
   localparam int STEP_W      = $clog2(MAX_RESULTS + 1);

   typedef enum logic [0:0] {
      REG_SYNC_WORD = 1'b0,
      REG_DEV_ADDR  = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      KIND_TX_BYTE = 2'd0,
      KIND_RX_DATA = 2'd1,
      KIND_RX_DONE = 2'd2,
      KIND_RX_BAD  = 2'd3
   } kind_type;

   localparam logic OP_TX = 1'b0;
   localparam logic OP_RX = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] byte_in;
      logic [7:0] packet_type;
      logic [6:0] payload_len;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [7:0]  rx_type;
      logic [15:0] rx_length;
   } result_type;

endpackage

/* rtl/spf_ifs.sv */
interface spf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] byte_in;
   logic [7:0] packet_type;
   logic [6:0] payload_len;

   modport source (output valid, op, byte_in, packet_type, payload_len, input ready);
   modport sink   (input valid, op, byte_in, packet_type, payload_len, output ready);
endinterface

interface spf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic [7:0]  rx_type;
   logic [15:0] rx_length;
   logic        last;

   modport source (output valid, kind, out_byte, rx_type, rx_length, last, input ready);
   modport sink   (input valid, kind, out_byte, rx_type, rx_length, last, output ready);
endinterface

interface spf_csr_if;
   logic                      valid;
   logic                      ready;
   spf_pkg::csr_reg_type      index;
   logic [31:0]               data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/spf_tx_framer.sv */
module spf_tx_framer (
   input  logic                       clock,
   input  logic                       reset,
   input  spf_pkg::item_type          item,
   input  logic [spf_pkg::STEP_W-1:0] step,
   input  logic                       commit,
   input  logic [15:0]                sync_word,
   input  logic [31:0]                dev_addr,
   output spf_pkg::result_type        res,
   output logic [spf_pkg::STEP_W-1:0] count
);

   logic [6:0]  tx_count_ff, tx_count_in;
   logic [6:0]  tx_total_ff, tx_total_in;
   logic [15:0] tx_sum_ff, tx_sum_in;

   logic        hdr;
   logic [6:0]  total;
   logic [15:0] wl;
   logic [15:0] base_sum;
   logic [6:0]  cnt;
   logic [6:0]  tot;
   logic [15:0] sum0;
   logic [15:0] sum_d;
   logic [6:0]  cnt_n;
   logic        zero;
   logic        fin;
   logic [15:0] sum_out;
   logic [spf_pkg::STEP_W-1:0] nh;
   logic [spf_pkg::STEP_W-1:0] rel;
   logic [7:0]  hdr_byte;
   logic [7:0]  byte_sel;

   always_comb begin
      hdr = (tx_count_ff == 7'd0);
      if ({1'b0, item.payload_len} > 8'(spf_pkg::MAX_PAYLOAD)) begin
         total = 7'(spf_pkg::MAX_PAYLOAD);
      end else begin
         total = item.payload_len;
      end
      wl       = 16'(total) + 16'd2;
      base_sum = 16'(wl[15:8]) + 16'(wl[7:0]) + 16'(item.packet_type);
      cnt      = hdr ? 7'd0 : tx_count_ff;
      tot      = hdr ? total : tx_total_ff;
      sum0     = hdr ? base_sum : tx_sum_ff;
      zero     = hdr && (total == 7'd0);
      sum_d    = sum0 + 16'(item.byte_in);
      cnt_n    = cnt + 7'd1;
      fin      = (cnt_n == tot);
      sum_out  = zero ? sum0 : sum_d;
      nh       = hdr ? spf_pkg::STEP_W'(spf_pkg::HDR_BYTES) : '0;

      if (zero) begin
         count = spf_pkg::STEP_W'(spf_pkg::HDR_BYTES + 2);
      end else begin
         count = nh + (fin ? spf_pkg::STEP_W'(3) : spf_pkg::STEP_W'(1));
      end

      case (step)
         4'd0:    hdr_byte = sync_word[15:8];
         4'd1:    hdr_byte = sync_word[7:0];
         4'd2:    hdr_byte = dev_addr[31:24];
         4'd3:    hdr_byte = dev_addr[23:16];
         4'd4:    hdr_byte = dev_addr[15:8];
         4'd5:    hdr_byte = dev_addr[7:0];
         4'd6:    hdr_byte = item.packet_type;
         4'd7:    hdr_byte = wl[15:8];
         default: hdr_byte = wl[7:0];
      endcase

      rel = step - nh;
      if (step < nh) begin
         byte_sel = hdr_byte;
      end else if (zero) begin
         byte_sel = (rel == '0) ? sum_out[15:8] : sum_out[7:0];
      end else if (rel == '0) begin
         byte_sel = item.byte_in;
      end else if (rel == spf_pkg::STEP_W'(1)) begin
         byte_sel = sum_out[15:8];
      end else begin
         byte_sel = sum_out[7:0];
      end

      res.kind      = spf_pkg::KIND_TX_BYTE;
      res.out_byte  = byte_sel;
      res.rx_type   = 8'd0;
      res.rx_length = 16'd0;

      if (zero) begin
         tx_sum_in   = sum0;
         tx_total_in = 7'd0;
         tx_count_in = 7'd0;
      end else begin
         tx_sum_in   = sum_d;
         tx_total_in = tot;
         tx_count_in = fin ? 7'd0 : cnt_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_count_ff <= 7'd0;
         tx_total_ff <= 7'd0;
         tx_sum_ff   <= 16'd0;
      end else if (commit) begin
         tx_count_ff <= tx_count_in;
         tx_total_ff <= tx_total_in;
         tx_sum_ff   <= tx_sum_in;
      end
   end

endmodule

/* rtl/spf_rx_deframer.sv */
module spf_rx_deframer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 byte_in,
   input  logic [spf_pkg::STEP_W-1:0] step,
   input  logic                       commit,
   input  logic [15:0]                sync_word,
   output spf_pkg::result_type        res,
   output logic [spf_pkg::STEP_W-1:0] count
);

   // Byte positions within a received frame
   localparam logic [16:0] POS_START_HI = 17'd0;
   localparam logic [16:0] POS_START_LO = 17'd1;
   localparam logic [16:0] POS_TYPE     = 17'd6;
   localparam logic [16:0] POS_LEN_HI   = 17'd7;
   localparam logic [16:0] POS_LEN_LO   = 17'd8;

   logic [16:0] rx_count_ff, rx_count_in;
   logic [7:0]  rx_type_ff, rx_type_in;
   logic [15:0] rx_length_ff, rx_length_in;

   spf_pkg::result_type res0;
   spf_pkg::result_type res1;
   logic [16:0] rel;
   logic        complete;
   logic [15:0] len_full;

   always_comb begin
      rx_count_in  = rx_count_ff + 17'd1;
      rx_type_in   = rx_type_ff;
      rx_length_in = rx_length_ff;
      count        = '0;
      rel          = rx_count_ff - 17'd8;
      complete     = (rel >= {1'b0, rx_length_ff});
      len_full     = {rx_length_ff[15:8], byte_in};

      res0.kind      = spf_pkg::KIND_RX_BAD;
      res0.out_byte  = byte_in;
      res0.rx_type   = 8'd0;
      res0.rx_length = 16'd0;
      res1.kind      = spf_pkg::KIND_RX_DONE;
      res1.out_byte  = 8'd0;
      res1.rx_type   = rx_type_ff;
      res1.rx_length = rx_length_ff;

      if (rx_count_ff == POS_START_HI || rx_count_ff == POS_START_LO) begin
         if (byte_in != ((rx_count_ff == POS_START_HI) ? sync_word[15:8]
                                                       : sync_word[7:0])) begin
            count       = spf_pkg::STEP_W'(1);
            rx_count_in = 17'd0;
         end
      end else if (rx_count_ff == POS_TYPE) begin
         rx_type_in = byte_in;
      end else if (rx_count_ff == POS_LEN_HI) begin
         rx_length_in = {byte_in, 8'd0};
      end else if (rx_count_ff == POS_LEN_LO) begin
         rx_length_in = len_full;
         if (len_full == 16'd0) begin
            count       = spf_pkg::STEP_W'(1);
            rx_count_in = 17'd0;
         end
      end else if (rx_count_ff > POS_LEN_LO) begin
         // payload byte, then completion once the length is reached
         res0.kind = spf_pkg::KIND_RX_DATA;
         if (complete) begin
            count       = spf_pkg::STEP_W'(2);
            rx_count_in = 17'd0;
         end else begin
            count = spf_pkg::STEP_W'(1);
         end
      end

      res = (step == '0) ? res0 : res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff  <= 17'd0;
         rx_type_ff   <= 8'd0;
         rx_length_ff <= 16'd0;
      end else if (commit) begin
         rx_count_ff  <= rx_count_in;
         rx_type_ff   <= rx_type_in;
         rx_length_ff <= rx_length_in;
      end
   end

endmodule

/* rtl/sensor_packet_framer_deframer.sv */
// Channel    Dir  Beat carries
// ---------  ---  --------------------------------------------------------
// req_chan   in   op, byte_in, packet_type, payload_len (one byte per beat)
// rsp_chan   out  kind, out_byte, rx_type, rx_length, last
// csr_chan   in   index (sync word / device address), data; always ready
//
// One request beat causes 0 to 12 response beats, one per cycle while rsp_chan
// is ready; a beat with one response (the usual case) is then taken each cycle.
// A tx frame opener holds the request side while its 10 to 12 header, byte and
// checksum beats drain through the single response register. Synchronous
// active-high reset clears all frame state; registers return to 0xEF01 /
// 0xFFFFFFFF. A stalled response holds the item register and req_chan.ready.
module sensor_packet_framer_deframer (
   input logic     clock,
   input logic     reset,
   spf_req_if.sink   req_chan,
   spf_rsp_if.source rsp_chan,
   spf_csr_if.sink   csr_chan
);

   // Configuration registers
   logic [15:0] sync_word_ff;
   logic [31:0] dev_addr_ff;

   // Item register: the request beat being expanded
   logic                       itm_valid_ff, itm_valid_in;
   spf_pkg::item_type          itm_ff;
   logic [spf_pkg::STEP_W-1:0] step_ff, step_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   spf_pkg::result_type rsp_res_ff;
   logic                rsp_last_ff;

   spf_pkg::result_type        tx_res, rx_res, cur_res;
   logic [spf_pkg::STEP_W-1:0] tx_count, rx_count, cur_count;

   logic out_free;
   logic emit;
   logic is_last;
   logic done;
   logic accept;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= spf_pkg::SYNC_WORD_RESET;
         dev_addr_ff  <= spf_pkg::DEV_ADDR_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            spf_pkg::REG_SYNC_WORD: sync_word_ff <= csr_chan.data[15:0];
            spf_pkg::REG_DEV_ADDR:  dev_addr_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Per-direction framing logic; state only moves when the item finishes
   spf_tx_framer u_tx (
      .clock      (clock),
      .reset      (reset),
      .item       (itm_ff),
      .step       (step_ff),
      .commit     (done && (itm_ff.op == spf_pkg::OP_TX)),
      .sync_word  (sync_word_ff),
      .dev_addr   (dev_addr_ff),
      .res        (tx_res),
      .count      (tx_count)
   );

   spf_rx_deframer u_rx (
      .clock      (clock),
      .reset      (reset),
      .byte_in    (itm_ff.byte_in),
      .step       (step_ff),
      .commit     (done && (itm_ff.op == spf_pkg::OP_RX)),
      .sync_word  (sync_word_ff),
      .res        (rx_res),
      .count      (rx_count)
   );

   always_comb begin
      cur_res   = (itm_ff.op == spf_pkg::OP_RX) ? rx_res : tx_res;
      cur_count = (itm_ff.op == spf_pkg::OP_RX) ? rx_count : tx_count;
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      emit      = itm_valid_ff && (cur_count != '0) && out_free;
      is_last   = (step_ff == cur_count - spf_pkg::STEP_W'(1));
      // item retires on its last beat, or at once when it makes none
      done      = itm_valid_ff && ((cur_count == '0) || (emit && is_last));
      req_chan.ready = !itm_valid_ff || done;
      accept    = req_chan.valid && req_chan.ready;

      itm_valid_in = accept || (itm_valid_ff && !done);
      if (accept || done) begin
         step_in = '0;
      end else if (emit) begin
         step_in = step_ff + spf_pkg::STEP_W'(1);
      end else begin
         step_in = step_ff;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         itm_valid_ff <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         itm_valid_ff <= itm_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         itm_ff.op          <= req_chan.op;
         itm_ff.byte_in     <= req_chan.byte_in;
         itm_ff.packet_type <= req_chan.packet_type;
         itm_ff.payload_len <= req_chan.payload_len;
      end
      if (emit) begin
         rsp_res_ff  <= cur_res;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_res_ff.kind;
   assign rsp_chan.out_byte  = rsp_res_ff.out_byte;
   assign rsp_chan.rx_type   = rsp_res_ff.rx_type;
   assign rsp_chan.rx_length = rsp_res_ff.rx_length;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

/* verif/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One response beat as seen on rsp_chan, last flag included.
   typedef struct {
      spf_pkg::kind_type kind;
      logic [7:0]        out_byte;
      logic [7:0]        rx_type;
      logic [15:0]       rx_length;
      logic              last;
   } frame_beat_type;

   // Framer/deframer predictor plus the queue of response beats still owed.
   // Tx and rx directions keep independent state, as in the block.
   class scoreboard_type;
      logic [15:0] sync_word;
      logic [31:0] dev_addr;
      logic [6:0]  tx_count;
      logic [6:0]  tx_total;
      logic [15:0] tx_sum;
      logic [16:0] rx_count;
      logic [7:0]  rx_type_q;
      logic [15:0] rx_len_q;
      frame_beat_type expected_beats[$];
      frame_beat_type step_beats[$];
      int          errors;
      int          kind_count[4];

      function new();
         sync_word  = spf_pkg::SYNC_WORD_RESET;
         dev_addr   = spf_pkg::DEV_ADDR_RESET;
         tx_count   = '0;
         tx_total   = '0;
         tx_sum     = '0;
         rx_count   = '0;
         rx_type_q  = '0;
         rx_len_q   = '0;
         errors     = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function void write_reg(spf_pkg::csr_reg_type idx, logic [31:0] d);
         case (idx)
            spf_pkg::REG_SYNC_WORD: sync_word = d[15:0];
            spf_pkg::REG_DEV_ADDR:  dev_addr  = d;
            default: ;
         endcase
      endfunction

      function void queue_beat(spf_pkg::kind_type k, logic [7:0] b, logic [7:0] t = 8'h00,
                               logic [15:0] l = 16'h0000);
         frame_beat_type e;
         e.kind      = k;
         e.out_byte  = b;
         e.rx_type   = t;
         e.rx_length = l;
         e.last      = 1'b0;
         step_beats.push_back(e);
      endfunction

      function void queue_checksum();
         queue_beat(spf_pkg::KIND_TX_BYTE, tx_sum[15:8]);
         queue_beat(spf_pkg::KIND_TX_BYTE, tx_sum[7:0]);
      endfunction

      function void frame_tx(logic [7:0] b, logic [7:0] ptype, logic [6:0] plen);
         logic [6:0]  total;
         logic [15:0] wl;
         if (tx_count == 0) begin
            // frame opener: header goes out ahead of the byte
            total = (plen > spf_pkg::MAX_PAYLOAD) ? 7'(spf_pkg::MAX_PAYLOAD) : plen;
            wl = {9'd0, total} + 16'd2;
            queue_beat(spf_pkg::KIND_TX_BYTE, sync_word[15:8]);
            queue_beat(spf_pkg::KIND_TX_BYTE, sync_word[7:0]);
            queue_beat(spf_pkg::KIND_TX_BYTE, dev_addr[31:24]);
            queue_beat(spf_pkg::KIND_TX_BYTE, dev_addr[23:16]);
            queue_beat(spf_pkg::KIND_TX_BYTE, dev_addr[15:8]);
            queue_beat(spf_pkg::KIND_TX_BYTE, dev_addr[7:0]);
            queue_beat(spf_pkg::KIND_TX_BYTE, ptype);
            queue_beat(spf_pkg::KIND_TX_BYTE, wl[15:8]);
            queue_beat(spf_pkg::KIND_TX_BYTE, wl[7:0]);
            tx_sum   = {8'h00, wl[15:8]} + {8'h00, wl[7:0]} + {8'h00, ptype};
            tx_total = total;
            if (tx_total == 0) begin
               // empty payload: checksum right away, byte dropped
               queue_checksum();
               return;
            end
         end
         queue_beat(spf_pkg::KIND_TX_BYTE, b);
         tx_sum   = tx_sum + {8'h00, b};
         tx_count = tx_count + 7'd1;
         if (tx_count == tx_total) begin
            queue_checksum();
            tx_count = '0;
         end
      endfunction

      function void deframe_rx(logic [7:0] b);
         logic [7:0] want;
         if (rx_count < 2) begin
            want = (rx_count == 0) ? sync_word[15:8] : sync_word[7:0];
            if (b != want) begin
               rx_count = '0;
               queue_beat(spf_pkg::KIND_RX_BAD, b);
            end else begin
               rx_count = rx_count + 17'd1;
            end
         end else if (rx_count < 6) begin
            rx_count = rx_count + 17'd1;   // address bytes skipped
         end else if (rx_count == 6) begin
            rx_type_q = b;
            rx_count  = 17'd7;
         end else if (rx_count == 7) begin
            rx_len_q = {b, 8'h00};
            rx_count = 17'd8;
         end else if (rx_count == 8) begin
            rx_len_q[7:0] = b;
            if (rx_len_q == 0) begin
               rx_count = '0;
               queue_beat(spf_pkg::KIND_RX_BAD, b);
            end else begin
               rx_count = 17'd9;
            end
         end else begin
            queue_beat(spf_pkg::KIND_RX_DATA, b);
            if (rx_count - 17'd8 >= {1'b0, rx_len_q}) begin
               queue_beat(spf_pkg::KIND_RX_DONE, 8'h00, rx_type_q, rx_len_q);
               rx_count = '0;
            end else begin
               rx_count = rx_count + 17'd1;
            end
         end
      endfunction

      function void note_item(spf_pkg::item_type it);
         step_beats.delete();
         if (it.op == spf_pkg::OP_TX)
            frame_tx(it.byte_in, it.packet_type, it.payload_len);
         else
            deframe_rx(it.byte_in);
         if (step_beats.size() != 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
         foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= 30)
               $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(frame_beat_type got);
         frame_beat_type want;
         if (expected_beats.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0t: unexpected beat, expected none, got kind %0d byte %02h",
                        $time, got.kind, got.out_byte);
            return;
         end
         want = expected_beats.pop_front();
         kind_count[int'(got.kind)]++;
         compare_field("kind", want.kind, got.kind);
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("rx_type", want.rx_type, got.rx_type);
         compare_field("rx_length", want.rx_length, got.rx_length);
         compare_field("last", want.last, got.last);
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // payload bytes still owed to the open tx frame
      function int tx_left();
         return (tx_count == 0) ? 0 : int'(tx_total) - int'(tx_count);
      endfunction

      // data bytes still owed to the open rx frame (0 while in the header)
      function int rx_left();
         return (rx_count >= 9) ? int'(rx_len_q) + 9 - int'(rx_count) : 0;
      endfunction
   endclass

   localparam int PHASE_ITEMS  = 125;   // minimum count of random beats per idling phase
   localparam int DRAIN_CYCLES = 16;    // covers beats still inside the block
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT  = 5000;  // cycles without any handshake

   logic clock;
   logic reset;

   spf_req_if req ();
   spf_rsp_if rsp ();
   spf_csr_if csr ();

   sensor_packet_framer_deframer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   scoreboard_type sb = new();

   int          send_idle_pct;
   int          rsp_stall_pct;
   logic        rsp_hold;
   int          phase_items;
   int          total_items;
   int unsigned quiet_cycles;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Response side: check every accepted beat against the oldest owed beat,
   // then pick next cycle's ready. Values read here are the pre-edge ones.
   always @(posedge clock) begin
      frame_beat_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind      = spf_pkg::kind_type'(rsp.kind);
         got.out_byte  = rsp.out_byte;
         got.rx_type   = rsp.rx_type;
         got.rx_length = rsp.rx_length;
         got.last      = rsp.last;
         sb.check_result(got);
      end
      rsp.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d beats still owed",
                  $time, QUIET_LIMIT, sb.pending());
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic spf_pkg::item_type mk_item(logic op, logic [7:0] b, logic [7:0] t,
                                                 logic [6:0] l);
      spf_pkg::item_type it;
      it.op          = op;
      it.byte_in     = b;
      it.packet_type = t;
      it.payload_len = l;
      return it;
   endfunction

   function automatic spf_pkg::item_type rand_item(logic op);
      return mk_item(op, 8'($urandom), 8'($urandom), 7'($urandom));
   endfunction

   // Offer one beat, with random idle gaps ahead of it, and hold it until
   // taken. Valid is left high so back-to-back beats need no re-raise.
   task automatic send_item(spf_pkg::item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.op          <= it.op;
      req.byte_in     <= it.byte_in;
      req.packet_type <= it.packet_type;
      req.payload_len <= it.payload_len;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_item(it);
      phase_items++;
      total_items++;
   endtask

   // Stop offering and wait until every owed beat has come back, plus a
   // margin for header bytes that produce no beat.
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(spf_pkg::csr_reg_type idx, logic [31:0] d);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= d;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      sb.write_reg(idx, d);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // One round of random traffic: mostly well-formed frames with random
   // content, first closing whatever frame is still open, plus some corrupt
   // start codes, zero lengths and idle garbage on the rx side. Tx and rx
   // beats are interleaved in about half of the rounds.
   task automatic run_round();
      spf_pkg::item_type tx_q[$];
      spf_pkg::item_type rx_q[$];
      spf_pkg::item_type it;
      int          n;
      int          r;
      logic        mix;
      logic [6:0]  plen;
      logic [15:0] flen;
      logic [15:0] sc;
      if ($urandom_range(99) < 60) begin
         n = sb.tx_left();
         if (n == 0) begin
            r = $urandom_range(99);
            if (r < 4)
               plen = 7'd0;
            else if (r < 8)
               plen = 7'($urandom_range(65, 127));   // saturates to MAX_PAYLOAD
            else if (r < 11)
               plen = 7'(spf_pkg::MAX_PAYLOAD);
            else
               plen = 7'($urandom_range(1, 8));
            n = (plen == 0) ? 1 : ((plen > spf_pkg::MAX_PAYLOAD) ? spf_pkg::MAX_PAYLOAD
                                                                 : int'(plen));
            it = rand_item(spf_pkg::OP_TX);
            it.payload_len = plen;
            tx_q.push_back(it);
            n--;
         end
         repeat (n) tx_q.push_back(rand_item(spf_pkg::OP_TX));
      end
      if ($urandom_range(99) < 60) begin
         n = sb.rx_left();
         if (n != 0) begin
            repeat ((n > 400) ? 400 : n) rx_q.push_back(rand_item(spf_pkg::OP_RX));
         end else begin
            sc = sb.sync_word;
            r = $urandom_range(99);
            if (r < 5)
               sc[15:8] = sc[15:8] ^ 8'($urandom_range(1, 255));
            else if (r < 10)
               sc[7:0] = sc[7:0] ^ 8'($urandom_range(1, 255));
            r = $urandom_range(99);
            if (r < 5)
               flen = 16'd0;
            else if (r < 7)
               flen = 16'($urandom_range(100, 300));
            else
               flen = 16'($urandom_range(1, 12));
            rx_q.push_back(mk_item(spf_pkg::OP_RX, sc[15:8], 8'($urandom), 7'($urandom)));
            rx_q.push_back(mk_item(spf_pkg::OP_RX, sc[7:0], 8'($urandom), 7'($urandom)));
            repeat (5) rx_q.push_back(rand_item(spf_pkg::OP_RX));   // address + type
            rx_q.push_back(mk_item(spf_pkg::OP_RX, flen[15:8], 8'($urandom), 7'($urandom)));
            rx_q.push_back(mk_item(spf_pkg::OP_RX, flen[7:0], 8'($urandom), 7'($urandom)));
            repeat (flen) rx_q.push_back(rand_item(spf_pkg::OP_RX));
         end
      end
      if ($urandom_range(99) < 15)
         repeat ($urandom_range(1, 3)) rx_q.push_back(rand_item(spf_pkg::OP_RX));
      mix = 1'($urandom_range(1));
      while (tx_q.size() != 0 || rx_q.size() != 0) begin
         if (rx_q.size() == 0 || (tx_q.size() != 0 && (!mix || $urandom_range(1) == 0)))
            it = tx_q.pop_front();
         else
            it = rx_q.pop_front();
         send_item(it);
      end
   endtask

   initial begin
      // rx frame with a zero length field, then a one-byte rx frame
      logic [7:0] zero_len_hdr[9] = '{8'hEF, 8'h01, 8'h00, 8'hFF, 8'h12, 8'h34,
                                      8'hA5, 8'h00, 8'h00};
      logic [7:0] one_len_hdr[9]  = '{8'hEF, 8'h01, 8'h5A, 8'h5A, 8'h5A, 8'h5A,
                                      8'hFF, 8'h00, 8'h01};
      int send_idle[4] = '{0, 62, 0, 23};
      int rsp_stall[4] = '{0, 0, 62, 23};
      logic paused;

      reset           = 1'b1;
      req.valid       = 1'b0;
      req.op          = spf_pkg::OP_TX;
      req.byte_in     = '0;
      req.packet_type = '0;
      req.payload_len = '0;
      csr.valid       = 1'b0;
      csr.index       = spf_pkg::REG_SYNC_WORD;
      csr.data        = '0;
      rsp_hold        = 1'b0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      phase_items     = 0;
      total_items     = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats, reset register values, no idling.
      send_item(mk_item(spf_pkg::OP_RX, 8'h00, 8'h00, 7'd0));   // idle garbage
      send_item(mk_item(spf_pkg::OP_RX, 8'hEF, 8'h00, 7'd0));
      send_item(mk_item(spf_pkg::OP_RX, 8'h55, 8'h00, 7'd0));   // bad second start byte
      send_item(mk_item(spf_pkg::OP_TX, 8'hFF, 8'hFF, 7'd0));   // empty tx payload
      foreach (zero_len_hdr[i])
         send_item(mk_item(spf_pkg::OP_RX, zero_len_hdr[i], 8'h00, 7'd0));
      send_item(mk_item(spf_pkg::OP_TX, 8'h00, 8'h00, 7'd1));   // one-byte tx frame, 12 beats
      foreach (one_len_hdr[i]) begin
         send_item(mk_item(spf_pkg::OP_RX, one_len_hdr[i], 8'h00, 7'd0));
         // tx opener landing mid rx header; length saturates, frame stays open
         if (i == 4) send_item(mk_item(spf_pkg::OP_TX, 8'h80, 8'h3C, 7'd127));
      end
      send_item(mk_item(spf_pkg::OP_RX, 8'hFF, 8'h00, 7'd0));   // data + completion

      // Random phases, one per idling mix, each with its own register values.
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_reg(spf_pkg::REG_SYNC_WORD, {16'($urandom), 16'h0000});
               write_reg(spf_pkg::REG_DEV_ADDR, 32'h0000_0000);
            end
            1: begin
               write_reg(spf_pkg::REG_SYNC_WORD, {16'($urandom), 16'hFFFF});
               write_reg(spf_pkg::REG_DEV_ADDR, 32'hFFFF_FFFF);
            end
            2: begin
               write_reg(spf_pkg::REG_SYNC_WORD, $urandom);
               write_reg(spf_pkg::REG_DEV_ADDR, $urandom);
            end
            default: begin
               write_reg(spf_pkg::REG_SYNC_WORD, {16'($urandom), spf_pkg::SYNC_WORD_RESET});
               write_reg(spf_pkg::REG_DEV_ADDR, $urandom);
            end
         endcase
         send_idle_pct = send_idle[phase];
         rsp_stall_pct = rsp_stall[phase];
         phase_items   = 0;
         paused        = 1'b0;
         // Receiver holds off while the sender keeps offering, so the
         // block backs up and drops req ready.
         if (phase == 0) begin
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         while (phase_items < PHASE_ITEMS) begin
            run_round();
            // sender pause until the block has fully drained
            if (phase == 1 && !paused && phase_items >= PHASE_ITEMS / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end

      wait_idle();
      $display("summary: %0d request beats over four idling mixes and four register settings",
               total_items);
      $display("summary: beats checked: %0d tx wire, %0d rx data, %0d rx done, %0d rx bad",
               sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3]);
      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/spf_pkg.sv
rtl/spf_ifs.sv
rtl/spf_tx_framer.sv
rtl/spf_rx_deframer.sv
rtl/sensor_packet_framer_deframer.sv
verif/tb.sv
